>>> sv/atoc_pkg.sv
// Shared types, constants and helper functions for the alpha texel outline converter.
// No dependencies; every other file imports this package.
package atoc_pkg;

  localparam int unsigned MAX_WIDTH = 1024;  // deepest row the line buffers hold
  localparam int unsigned COORD_W   = 10;    // column / row coordinate width
  localparam int unsigned DIM_W     = 11;    // width of the size registers
  localparam int unsigned NIB_W     = 4;     // alpha nibble
  localparam int unsigned TEX_W     = 16;    // A4R4G4B4 word
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 11;    // widest register

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [11:0] WHITE_RGB = 12'hFFF;

  // Line buffer control from the top level
  typedef struct packed {
    logic               rd_en;    // word accepted: read both rows, write new pixel
    logic [COORD_W-1:0] rd_addr;  // column of the accepted word
    logic [NIB_W-1:0]   pix;      // its alpha nibble
    logic               wb_en;    // staged word retires: push row-above into second row
    logic [COORD_W-1:0] wb_addr;  // column of the staged word
  } lb_ctrl_t;

  // Clamp a size register to 3..MAX_WIDTH and return the last index (size - 1).
  function automatic logic [COORD_W-1:0] last_index(input logic [DIM_W-1:0] v);
    logic [COORD_W-1:0] res;
    if (v < DIM_W'(3)) begin
      res = COORD_W'(2);
    end else if (v > DIM_W'(MAX_WIDTH)) begin
      res = COORD_W'(MAX_WIDTH - 1);
    end else begin
      res = COORD_W'(v - DIM_W'(1));
    end
    return res;
  endfunction

  // Nonzero alpha gives white with that alpha, zero gives a fully clear texel.
  function automatic logic [TEX_W-1:0] make_texel(input logic [NIB_W-1:0] a);
    return (a != '0) ? {a, WHITE_RGB} : '0;
  endfunction

  // Outline alpha: three quarters of the OR of the cross neighbors, ORed with the center.
  function automatic logic [NIB_W-1:0] outline_alpha(
    input logic [NIB_W-1:0] nbr,
    input logic [NIB_W-1:0] cen
  );
    logic [NIB_W+1:0] x3;
    x3 = {2'b00, nbr} + {1'b0, nbr, 1'b0};
    return x3[NIB_W+1:2] | cen;
  endfunction

endpackage

>>> sv/atoc_line_buf.sv
// Two row line buffers holding the alpha nibbles of the previous two image rows.
// Depends on atoc_pkg (lb_ctrl_t, MAX_WIDTH, widths).
module atoc_line_buf (
  input  logic                      clk_i,
  input  atoc_pkg::lb_ctrl_t        ctrl_i,
  output logic [atoc_pkg::NIB_W-1:0] row1_o,  // pixel one row above the read column
  output logic [atoc_pkg::NIB_W-1:0] row2_o   // pixel two rows above the read column
);
  import atoc_pkg::*;

  logic [NIB_W-1:0] row1_mem [MAX_WIDTH];
  logic [NIB_W-1:0] row2_mem [MAX_WIDTH];
  logic [NIB_W-1:0] row1_q;
  logic [NIB_W-1:0] row2_q;

  // Read-old-data: the new pixel replaces the row-above entry it reads.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      row1_q                  <= row1_mem[ctrl_i.rd_addr];
      row1_mem[ctrl_i.rd_addr] <= ctrl_i.pix;
    end
  end

  // Row-above value moves down one row when its word retires; its column
  // always differs from the column being read in the same cycle.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      row2_q <= row2_mem[ctrl_i.rd_addr];
    end
    if (ctrl_i.wb_en) begin
      row2_mem[ctrl_i.wb_addr] <= row1_q;
    end
  end

  assign row1_o = row1_q;
  assign row2_o = row2_q;

endmodule

>>> sv/alpha_texel_outline_converter_top.sv
// Top level of the alpha texel outline converter: counters, config, window and output.
// Depends on atoc_pkg and atoc_line_buf.
//
// Converts a raster stream of 8-bit glyph intensities (one word per pixel) into
// A4R4G4B4 texels with column/row and an end-of-image flag. Alpha is the top nibble
// of the intensity; nonzero alpha gives white, zero gives an all-zero texel. Sustained
// rate is one word per clock on both sides; input and output may stall independently.
// Plain mode: every pixel gives one texel, through the stage register and then the output
// register. Border mode: the texel of pixel (r, c) is built from its cross neighbors and
// is output behind the pixel at (r+1, c+1), through the stage and output registers;
// edge pixels give no texel. The neighbors come from two 1024 x 4-bit line
// buffers, each read once and written once per word, which sets the single-cycle rate.
// Sizes are clamped to 3..1024. Any write to a known register restarts the image at
// (0, 0); write config only while the block is idle.
module alpha_texel_outline_converter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [atoc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [atoc_pkg::CFG_W-1:0]     cfg_data_i,
  // input words
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     intensity_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [atoc_pkg::TEX_W-1:0]     texel_o,
  output logic [atoc_pkg::COORD_W-1:0]   col_index_o,
  output logic [atoc_pkg::COORD_W-1:0]   row_index_o,
  output logic                           last_o
);
  import atoc_pkg::*;

  // ---------------- configuration ----------------
  logic               border_q;
  logic [COORD_W-1:0] col_last_q, row_last_q;   // clamped size - 1
  logic               restart;

  assign restart = cfg_we_i && (cfg_index_i == REG_BORDER_MODE ||
                                cfg_index_i == REG_IMAGE_WIDTH ||
                                cfg_index_i == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      border_q   <= 1'b0;
      col_last_q <= COORD_W'(511);
      row_last_q <= COORD_W'(511);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BORDER_MODE:  border_q   <= cfg_data_i[0];
        REG_IMAGE_WIDTH:  col_last_q <= last_index(cfg_data_i);
        REG_IMAGE_HEIGHT: row_last_q <= last_index(cfg_data_i);
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------- handshake ----------------
  logic in_acc;      // input word taken
  logic stg_v_q;     // stage register holds a word
  logic stg_adv;     // stage word retires into the output register
  logic out_v_q;

  assign stg_adv    = stg_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !stg_v_q || stg_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // ---------------- raster position ----------------
  logic [COORD_W-1:0] col_q, row_q;
  logic               img_last;

  assign img_last = (col_q == col_last_q) && (row_q == row_last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (restart) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (col_q == col_last_q) begin
        col_q <= '0;
        row_q <= (row_q == row_last_q) ? '0 : row_q + COORD_W'(1);
      end else begin
        col_q <= col_q + COORD_W'(1);
      end
    end
  end

  // ---------------- stage register ----------------
  logic [NIB_W-1:0]   stg_pix_q;
  logic [COORD_W-1:0] stg_col_q, stg_row_q;
  logic               stg_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
    end else if (in_acc) begin
      stg_v_q <= 1'b1;
    end else if (stg_adv) begin
      stg_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stg_pix_q  <= intensity_i[7:4];
      stg_col_q  <= col_q;
      stg_row_q  <= row_q;
      stg_last_q <= img_last;
    end
  end

  // ---------------- line buffers ----------------
  lb_ctrl_t         lb_ctrl;
  logic [NIB_W-1:0] up1, up2;   // stage column, one and two rows up

  always_comb begin
    lb_ctrl.rd_en   = in_acc;
    lb_ctrl.rd_addr = col_q;
    lb_ctrl.pix     = intensity_i[7:4];
    lb_ctrl.wb_en   = stg_adv;
    lb_ctrl.wb_addr = stg_col_q;
  end

  atoc_line_buf u_line_buf (
    .clk_i  (clk_i),
    .ctrl_i (lb_ctrl),
    .row1_o (up1),
    .row2_o (up2)
  );

  // ---------------- 3-column window history ----------------
  // Column c-1 keeps its pixel and both rows above; column c-2 needs only the row above.
  logic [NIB_W-1:0] h1_pix_q, h1_up1_q, h1_up2_q, h2_up1_q;

  always_ff @(posedge clk_i) begin
    if (stg_adv) begin
      h1_pix_q <= stg_pix_q;
      h1_up1_q <= up1;
      h1_up2_q <= up2;
      h2_up1_q <= h1_up1_q;
    end
  end

  // ---------------- result ----------------
  // Border window centered one row up, one column left of the stage word:
  // up = h1_up2, down = h1_pix, left = h2_up1, right = up1, center = h1_up1.
  logic               res_v;
  logic [TEX_W-1:0]   res_texel;
  logic [COORD_W-1:0] res_col, res_row;

  always_comb begin
    if (border_q) begin
      res_v     = (stg_col_q >= COORD_W'(2)) && (stg_row_q >= COORD_W'(2));
      res_texel = make_texel(outline_alpha(h1_up2_q | h1_pix_q | h2_up1_q | up1, h1_up1_q));
      res_col   = stg_col_q - COORD_W'(1);
      res_row   = stg_row_q - COORD_W'(1);
    end else begin
      res_v     = 1'b1;
      res_texel = make_texel(stg_pix_q);
      res_col   = stg_col_q;
      res_row   = stg_row_q;
    end
  end

  // ---------------- output register ----------------
  logic [TEX_W-1:0]   out_texel_q;
  logic [COORD_W-1:0] out_col_q, out_row_q;
  logic               out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (stg_adv) begin
      out_v_q <= res_v;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_adv) begin
      out_texel_q <= res_texel;
      out_col_q   <= res_col;
      out_row_q   <= res_row;
      out_last_q  <= stg_last_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign texel_o     = out_texel_q;
  assign col_index_o = out_col_q;
  assign row_index_o = out_row_q;
  assign last_o      = out_last_q;

endmodule
